### rtl/plti_pkg.sv
`timescale 1ns / 1ps
package plti_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW = 4;
    localparam int ValW = 32;
    localparam int CntW = 5;
    localparam int DifW = ValW + 1;
    localparam int ProdW = 2 * DifW;
    localparam int QuotW = 63;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_REV  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               valid;
        logic signed [ValW-1:0] x;
        logic signed [ValW-1:0] y;
    } t_cell_data;
endpackage

### rtl/plti_cell.sv
`timescale 1ns / 1ps
module plti_cell (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic                               i_shift,
    input  logic signed [plti_pkg::ValW-1:0]  i_pix,
    input  logic signed [plti_pkg::ValW-1:0]  i_wld,
    input  logic signed [plti_pkg::ValW-1:0]  i_nxt_pix,
    input  logic signed [plti_pkg::ValW-1:0]  i_nxt_wld,
    output logic signed [plti_pkg::ValW-1:0]  o_pix,
    output logic signed [plti_pkg::ValW-1:0]  o_wld
);
    // Each cell holds one entry; during a scan the row rotates toward cell 0.
    logic signed [plti_pkg::ValW-1:0] r_pix;
    logic signed [plti_pkg::ValW-1:0] r_wld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pix <= i_pix;
            r_wld <= i_wld;
        end else if (i_shift) begin
            r_pix <= i_nxt_pix;
            r_wld <= i_nxt_wld;
        end
    end

    assign o_pix = r_pix;
    assign o_wld = r_wld;
endmodule

### rtl/plti_div.sv
`timescale 1ns / 1ps
module plti_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [plti_pkg::ProdW-1:0]        i_num,
    input  logic [plti_pkg::DifW-1:0]         i_den,
    output logic                              o_done,
    output logic [plti_pkg::QuotW-1:0]        o_quot
);
    // Restoring divider, one quotient bit per cycle, quotient capped at 2^62.
    localparam int PW = plti_pkg::ProdW;
    localparam int DW = plti_pkg::DifW;
    localparam int BW = $clog2(PW + 1);

    logic [PW-1:0] r_num;
    logic [PW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [BW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_trial;
    logic [DW:0]   n_diff;

    always_comb begin
        n_trial = {r_rem[DW-1:0], r_num[PW-1]};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= BW'(PW);
            end else if (r_busy) begin
                r_num <= {r_num[PW-2:0], 1'b0};
                if (!n_diff[DW]) begin
                    r_rem <= n_diff;
                    r_quo <= {r_quo[PW-2:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[PW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == BW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    localparam logic [PW-1:0] Cap = PW'(1) << (plti_pkg::QuotW - 1);
    assign o_done = r_done;
    assign o_quot = (r_quo > Cap) ? Cap[plti_pkg::QuotW-1:0] : r_quo[plti_pkg::QuotW-1:0];
endmodule

### rtl/piecewise_linear_table_interp.sv
`timescale 1ns / 1ps
// Piecewise linear table interpolator, signed Q16.16.
// Input stream (s_axis): mode 0 loads entry entry_index with a pixel/world
// pair, mode 1 maps pixel to world, mode 2 maps world to pixel. Every input
// transfer yields exactly one output transfer (m_axis): mapped value and a
// saturation flag; loads and mode 3 return zero.
// i_cfg_we/i_cfg_wdata set the number of entries in use (clamped to 2..16);
// write only while idle.
// The table sits in a row of 16 cells. A query rotates the row through
// cell 0, then picks the interval, multiplies, runs the restoring divide
// (66 steps plus done), sums and registers the result. When no divide is
// needed (no bracket in forward mode, or a zero-width interval), the sum
// is skipped and the result is registered straight from the multiply
// state. A load or mode 3 goes from idle straight to the output state.
// One item is processed at a time; the next is taken in the cycle the
// result is read. Reset (synchronous, active low) clears control and sets
// the count to 2; table contents stay undefined until loaded. A stalled
// receiver holds the result in the output register and blocks new input.
module piecewise_linear_table_interp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] mode, [5:2] entry_index, [37:6] pixel_entry,
    // [69:38] world_entry, [101:70] query_value, [103:102] zero
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] mapped_value
    output logic [31:0] m_axis_tdata,
    // [0] saturated
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);
    localparam int D  = plti_pkg::TableDepth;
    localparam int VW = plti_pkg::ValW;
    localparam int DW = plti_pkg::DifW;
    localparam int PW = plti_pkg::ProdW;
    localparam int IW = plti_pkg::IdxW;
    localparam int CW = plti_pkg::CntW;
    localparam logic signed [DW+1:0] VMax = (DW+2)'((64'sd1 <<< (VW - 1)) - 1);
    localparam logic signed [DW+1:0] VMin = -VMax - 1;

    plti_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_cnt;
    logic [IW:0]   r_step;
    logic [1:0]    r_mode;
    logic signed [VW-1:0] r_q;
    logic signed [VW-1:0] r_out;
    logic r_sat, r_ovld;

    // scan result registers
    logic r_found;
    logic signed [VW-1:0] r_fx0, r_fx1, r_fy0, r_fy1;   // first bracket
    logic signed [VW-1:0] r_ax0, r_ax1, r_ay0, r_ay1;   // first interval
    logic signed [VW-1:0] r_bx0, r_bx1, r_by0, r_by1;   // last interval
    logic signed [VW-1:0] r_prevx, r_prevy;
    logic signed [VW-1:0] r_sx0, r_sx1, r_sy0, r_sy1;   // selected
    logic [PW-1:0] w_prod;
    logic          r_neg;
    logic          r_direct;

    logic signed [VW-1:0] w_pix [D];
    logic signed [VW-1:0] w_wld [D];
    logic                 w_shift;
    logic                 w_load;
    logic [CW-1:0]        w_n;

    logic [1:0]  in_mode;
    logic [IW-1:0] in_idx;
    assign in_mode = s_axis_tdata[1:0];
    assign in_idx  = s_axis_tdata[5:2];

    assign s_axis_tready = (r_st == plti_pkg::ST_IDLE) && (!r_ovld || m_axis_tready);
    assign w_load  = s_axis_tvalid && s_axis_tready && (in_mode == plti_pkg::MODE_LOAD);
    assign w_shift = (r_st == plti_pkg::ST_SCAN) && !r_step[IW];
    assign w_n = (r_cnt < CW'(2)) ? CW'(2) : ((r_cnt > CW'(D)) ? CW'(D) : r_cnt);

    for (genvar g = 0; g < D; g++) begin : g_cell
        plti_cell u_cell (
            .i_clk     (i_clk),
            .i_we      (w_load && (in_idx == IW'(g))),
            .i_shift   (w_shift),
            .i_pix     (s_axis_tdata[37:6]),
            .i_wld     (s_axis_tdata[69:38]),
            .i_nxt_pix (w_pix[(g + 1) % D]),
            .i_nxt_wld (w_wld[(g + 1) % D]),
            .o_pix     (w_pix[g]),
            .o_wld     (w_wld[g])
        );
    end

    // during scan, cell 0 holds entry r_step; keys depend on direction
    logic signed [VW-1:0] c_x, c_y;
    logic [IW-1:0] w_k;
    assign w_k = r_step[IW-1:0];
    assign c_x = (r_mode == plti_pkg::MODE_FWD) ? w_pix[0] : w_wld[0];
    assign c_y = (r_mode == plti_pkg::MODE_FWD) ? w_wld[0] : w_pix[0];

    logic w_rising, w_in;
    assign w_rising = r_bx1 > r_ax0; // valid only for reverse after scan
    always_comb begin
        if (r_mode == plti_pkg::MODE_FWD)
            w_in = (r_q >= r_prevx) && (r_q <= c_x);
        else
            w_in = 1'b0;
    end

    // reverse bracket test needs the rising flag, which is known only at the
    // end; record both directions
    logic r_fndr, r_fndf;
    logic signed [VW-1:0] r_rx0, r_rx1, r_ry0, r_ry1, r_gx0, r_gx1, r_gy0, r_gy1;
    logic w_inr, w_inf;
    assign w_inr = (r_q >= r_prevx) && (r_q <= c_x);
    assign w_inf = (r_q <= r_prevx) && (r_q >= c_x);

    logic w_div_start, w_div_done;
    logic [plti_pkg::QuotW-1:0] w_quot;
    logic signed [DW-1:0] w_dx;
    assign w_dx = DW'(r_sx1) - DW'(r_sx0);

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (w_dx[DW-1] ? DW'(-w_dx) : w_dx),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            plti_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready) begin
                    if (in_mode == plti_pkg::MODE_FWD || in_mode == plti_pkg::MODE_REV)
                        n_st = plti_pkg::ST_SCAN;
                    else
                        n_st = plti_pkg::ST_OUT;
                end
            plti_pkg::ST_SCAN:
                if (r_step == (IW+1)'(D)) n_st = plti_pkg::ST_MUL;
            plti_pkg::ST_MUL:
                n_st = (r_direct || w_dx == '0) ? plti_pkg::ST_OUT : plti_pkg::ST_DIV;
            plti_pkg::ST_DIV:  if (w_div_done) n_st = plti_pkg::ST_SUM;
            plti_pkg::ST_SUM:  n_st = plti_pkg::ST_OUT;
            plti_pkg::ST_OUT:  n_st = plti_pkg::ST_IDLE;
            default:           n_st = plti_pkg::ST_IDLE;
        endcase
    end

    assign w_div_start = (r_st == plti_pkg::ST_MUL) && !r_direct && (w_dx != '0);

    // interval selection after the scan
    logic signed [VW-1:0] n_sx0, n_sx1, n_sy0, n_sy1;
    logic n_direct;
    logic signed [VW-1:0] n_dval;
    always_comb begin
        n_sx0 = r_bx0; n_sx1 = r_bx1; n_sy0 = r_by0; n_sy1 = r_by1;
        n_direct = 1'b0;
        n_dval = '0;
        if (r_mode == plti_pkg::MODE_FWD) begin
            if (r_q <= r_ax0) begin
                n_sx0 = r_ax0; n_sx1 = r_ax1; n_sy0 = r_ay0; n_sy1 = r_ay1;
            end else if (r_q >= r_bx1) begin
                n_sx0 = r_bx0; n_sx1 = r_bx1; n_sy0 = r_by0; n_sy1 = r_by1;
            end else if (r_found) begin
                n_sx0 = r_fx0; n_sx1 = r_fx1; n_sy0 = r_fy0; n_sy1 = r_fy1;
            end else begin
                n_direct = 1'b1;
                n_dval = r_by1;
            end
        end else if (w_rising ? r_fndr : r_fndf) begin
            if (w_rising) begin
                n_sx0 = r_rx0; n_sx1 = r_rx1; n_sy0 = r_ry0; n_sy1 = r_ry1;
            end else begin
                n_sx0 = r_gx0; n_sx1 = r_gx1; n_sy0 = r_gy0; n_sy1 = r_gy1;
            end
        end else if ((w_rising && r_q < r_ax0) || (!w_rising && r_q > r_ax0)) begin
            n_sx0 = r_ax0; n_sx1 = r_ax1; n_sy0 = r_ay0; n_sy1 = r_ay1;
        end
    end

    logic signed [DW-1:0] w_num, w_dy;
    logic [DW-1:0] w_mnum, w_mdy;
    assign w_num  = DW'(r_q) - DW'(r_sx0);
    assign w_dy   = DW'(r_sy1) - DW'(r_sy0);
    assign w_mnum = w_num[DW-1] ? DW'(-w_num) : w_num;
    assign w_mdy  = w_dy[DW-1] ? DW'(-w_dy) : w_dy;
    assign w_prod = PW'(w_mnum) * PW'(w_mdy);

    logic signed [DW+1:0] w_sum;
    assign w_sum = r_neg ? ((DW+2)'(r_sy0) - (DW+2)'($signed({1'b0, w_quot[DW:0]})))
                         : ((DW+2)'(r_sy0) + (DW+2)'($signed({1'b0, w_quot[DW:0]})));
    logic w_big;
    assign w_big = |w_quot[plti_pkg::QuotW-1:DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= plti_pkg::ST_IDLE;
            r_cnt  <= CW'(2);
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_cnt <= i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            if (r_st == plti_pkg::ST_OUT) r_ovld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            plti_pkg::ST_IDLE: begin
                r_mode  <= in_mode;
                r_q     <= s_axis_tdata[101:70];
                r_step  <= '0;
                r_found <= 1'b0;
                r_fndr  <= 1'b0;
                r_fndf  <= 1'b0;
                if (s_axis_tvalid && s_axis_tready) begin
                    r_out <= '0;
                    r_sat <= 1'b0;
                end
            end
            plti_pkg::ST_SCAN: begin
                r_step <= r_step + 1'b1;
                if (!r_step[IW]) begin
                    r_prevx <= c_x;
                    r_prevy <= c_y;
                    if (w_k == '0) begin
                        r_ax0 <= c_x; r_ay0 <= c_y;
                    end
                    if (w_k == IW'(1)) begin
                        r_ax1 <= c_x; r_ay1 <= c_y;
                    end
                    if ((IW+1)'(w_k) + (IW+1)'(2) == (IW+1)'(w_n)) begin
                        r_bx0 <= c_x; r_by0 <= c_y;
                    end
                    if ((IW+1)'(w_k) + (IW+1)'(1) == (IW+1)'(w_n)) begin
                        r_bx1 <= c_x; r_by1 <= c_y;
                    end
                    if (w_k != '0 && (IW+1)'(w_k) < (IW+1)'(w_n)) begin
                        if (w_in && !r_found) begin
                            r_found <= 1'b1;
                            r_fx0 <= r_prevx; r_fx1 <= c_x; r_fy0 <= r_prevy; r_fy1 <= c_y;
                        end
                        if (w_inr && !r_fndr) begin
                            r_fndr <= 1'b1;
                            r_rx0 <= r_prevx; r_rx1 <= c_x; r_ry0 <= r_prevy; r_ry1 <= c_y;
                        end
                        if (w_inf && !r_fndf) begin
                            r_fndf <= 1'b1;
                            r_gx0 <= r_prevx; r_gx1 <= c_x; r_gy0 <= r_prevy; r_gy1 <= c_y;
                        end
                    end
                end else begin
                    r_sx0 <= n_sx0; r_sx1 <= n_sx1; r_sy0 <= n_sy0; r_sy1 <= n_sy1;
                    r_direct <= n_direct;
                    r_out <= n_dval;
                end
            end
            plti_pkg::ST_MUL: begin
                r_neg  <= (w_num[DW-1] ^ w_dy[DW-1]) ^ w_dx[DW-1];
                if (!r_direct && w_dx == '0) begin
                    // zero-width interval yields y0
                    r_direct <= 1'b1;
                    r_out <= r_sy0;
                end
            end
            plti_pkg::ST_DIV: ;
            plti_pkg::ST_SUM: begin
                if (w_big || w_sum > VMax) begin
                    r_out <= (w_big && r_neg) ? VW'(VMin) : VW'(VMax);
                    r_sat <= 1'b1;
                end else if (w_sum < VMin) begin
                    r_sat <= 1'b1;
                    r_out <= VW'(VMin);
                end else begin
                    r_out <= VW'(w_sum);
                end
            end
            plti_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_sat;
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_mapped;

    class mapped_scoreboard;
        t_mapped pending[$];
        int      errors;

        function void note_input(t_mapped exp_r);
            pending.push_back(exp_r);
        endfunction

        task check_result(t_mapped got);
            t_mapped exp_r;
            if (pending.size() == 0) begin
                report_mismatch("result with none expected", 32'd0, got.value);
                return;
            end
            exp_r = pending.pop_front();
            if (got.value !== exp_r.value)
                report_mismatch("mapped_value", exp_r.value, got.value);
            if (got.sat !== exp_r.sat)
                report_mismatch("saturated", 32'(exp_r.sat), 32'(got.sat));
        endtask

        task report_mismatch(string what, logic [31:0] e, logic [31:0] g);
            $display("mismatch %s: expected %h got %h", what, e, g);
            errors++;
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we;
    logic [4:0]   i_cfg_wdata;

    piecewise_linear_table_interp u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    mapped_scoreboard sb = new();

    longint pix_col[plti_pkg::TableDepth];
    longint wld_col[plti_pkg::TableDepth];
    bit     written[plti_pkg::TableDepth];
    int     n_entries;
    bit     idle_on;
    int     hold_off;
    longint cycles;

    localparam longint VMax = 64'sd2147483647;
    localparam longint VMin = -64'sd2147483648;
    localparam longint CycleLimit = 2000000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint interp_line(longint v, longint x0, longint x1,
                                           longint y0, longint y1, output bit sat);
        logic signed [127:0] prod, quot;
        longint sum;
        sat = 1'b0;
        if (x1 == x0) return y0;
        prod = 128'(v - x0) * 128'(y1 - y0);
        quot = prod / 128'(x1 - x0);
        if (quot > 128'sd4611686018427387904) quot = 128'sd4611686018427387904;
        if (quot < -128'sd4611686018427387904) quot = -128'sd4611686018427387904;
        sum = y0 + longint'(quot);
        if (sum > VMax) begin sat = 1'b1; return VMax; end
        if (sum < VMin) begin sat = 1'b1; return VMin; end
        return sum;
    endfunction

    function automatic longint map_forward(longint p, output bit sat);
        int n;
        n = n_entries;
        sat = 1'b0;
        if (p <= pix_col[0])
            return interp_line(p, pix_col[0], pix_col[1], wld_col[0], wld_col[1], sat);
        if (p >= pix_col[n-1])
            return interp_line(p, pix_col[n-2], pix_col[n-1], wld_col[n-2],
                               wld_col[n-1], sat);
        for (int i = 0; i + 1 < n; i++)
            if (p >= pix_col[i] && p <= pix_col[i+1])
                return interp_line(p, pix_col[i], pix_col[i+1], wld_col[i],
                                   wld_col[i+1], sat);
        return wld_col[n-1];
    endfunction

    function automatic longint map_reverse(longint w, output bit sat);
        int n;
        bit rising, hit;
        n = n_entries;
        rising = wld_col[n-1] > wld_col[0];
        sat = 1'b0;
        for (int i = 0; i + 1 < n; i++) begin
            hit = rising ? (w >= wld_col[i] && w <= wld_col[i+1])
                         : (w <= wld_col[i] && w >= wld_col[i+1]);
            if (hit)
                return interp_line(w, wld_col[i], wld_col[i+1], pix_col[i],
                                   pix_col[i+1], sat);
        end
        if ((rising && w < wld_col[0]) || (!rising && w > wld_col[0]))
            return interp_line(w, wld_col[0], wld_col[1], pix_col[0], pix_col[1], sat);
        return interp_line(w, wld_col[n-2], wld_col[n-1], pix_col[n-2], pix_col[n-1], sat);
    endfunction

    function automatic t_mapped predict_mapping(plti_pkg::t_mode mode, logic [3:0] idx,
                                                logic [31:0] px, logic [31:0] wd,
                                                logic [31:0] q);
        t_mapped r;
        bit sat;
        longint v;
        r = '0;
        sat = 1'b0;
        case (mode)
            plti_pkg::MODE_LOAD: begin
                pix_col[idx] = longint'($signed(px));
                wld_col[idx] = longint'($signed(wd));
                written[idx] = 1'b1;
            end
            plti_pkg::MODE_FWD: begin
                v = map_forward(longint'($signed(q)), sat);
                r.value = v[31:0];
                r.sat = sat;
            end
            plti_pkg::MODE_REV: begin
                v = map_reverse(longint'($signed(q)), sat);
                r.value = v[31:0];
                r.sat = sat;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit table_ready();
        for (int i = 0; i < n_entries; i++)
            if (!written[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(plti_pkg::t_mode mode, logic [3:0] idx, logic [31:0] px,
                             logic [31:0] wd, logic [31:0] q);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, q, wd, px, idx, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(predict_mapping(mode, idx, px, wd, q));
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 8) << 16;
            3: return -($urandom_range(0, 8) << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_table(bit sorted);
        logic [31:0] p, w;
        int base, step, wstep;
        base = $urandom_range(0, 20000) - 10000;
        wstep = $urandom_range(0, 1) ? 1 : -1;
        for (int i = 0; i < n_entries; i++) begin
            step = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 5000);
            if (sorted) begin
                base += step;
                p = base << 8;
                w = (wstep * i * int'($urandom_range(0, 3000))) << 8;
            end else begin
                p = rand_value();
                w = rand_value();
            end
            send_item(plti_pkg::MODE_LOAD, i[3:0], p, w, 32'h0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_count(logic [4:0] c);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_entries = c < 2 ? 2 : (c > plti_pkg::TableDepth ? plti_pkg::TableDepth : c);
    endtask

    task automatic random_query();
        int r;
        logic [31:0] q;
        r = $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0)
            q = rand_value();
        else
            q = ($urandom_range(0, 30000) - 15000) << 8;
        if (r == 0)
            send_item(plti_pkg::MODE_NONE, 4'($urandom), $urandom, $urandom, $urandom);
        else if (r == 1)
            send_item(plti_pkg::MODE_LOAD, 4'($urandom_range(n_entries, 15)),
                      $urandom, $urandom, 32'd0);
        else
            send_item(r < 11 ? plti_pkg::MODE_FWD : plti_pkg::MODE_REV, 4'($urandom),
                      $urandom, $urandom, q);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        idle_on = 1'b1;
        hold_off = 0;
        n_entries = 2;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes on a two entry table
        send_item(plti_pkg::MODE_LOAD, 4'd0, 32'h0000_0000, 32'h0000_0000, 32'd0);
        send_item(plti_pkg::MODE_LOAD, 4'd1, 32'h0001_0000, 32'h7fff_ffff, 32'd0);
        send_item(plti_pkg::MODE_FWD, 4'd0, 32'd0, 32'd0, 32'h7fff_ffff);
        send_item(plti_pkg::MODE_FWD, 4'd0, 32'd0, 32'd0, 32'h8000_0000);
        send_item(plti_pkg::MODE_FWD, 4'd0, 32'd0, 32'd0, 32'h0000_8000);
        send_item(plti_pkg::MODE_REV, 4'd0, 32'd0, 32'd0, 32'h8000_0000);
        send_item(plti_pkg::MODE_REV, 4'd0, 32'd0, 32'd0, 32'h4000_0000);
        send_item(plti_pkg::MODE_NONE, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        // zero-width interval
        send_item(plti_pkg::MODE_LOAD, 4'd1, 32'h0000_0000, 32'h8000_0000, 32'd0);
        send_item(plti_pkg::MODE_FWD, 4'd0, 32'd0, 32'd0, 32'h0005_0000);
        send_item(plti_pkg::MODE_REV, 4'd0, 32'd0, 32'd0, 32'h7fff_ffff);
        // falling world column and non-monotonic pixels
        drain();
        write_count(5'd3);
        send_item(plti_pkg::MODE_LOAD, 4'd0, 32'h0000_0000, 32'h0003_0000, 32'd0);
        send_item(plti_pkg::MODE_LOAD, 4'd1, 32'h0005_0000, 32'h0001_0000, 32'd0);
        send_item(plti_pkg::MODE_LOAD, 4'd2, 32'h0002_0000, 32'h0002_0000, 32'd0);
        send_item(plti_pkg::MODE_FWD, 4'd0, 32'd0, 32'd0, 32'h0001_0000);
        send_item(plti_pkg::MODE_FWD, 4'd0, 32'd0, 32'd0, 32'h0004_0000);
        send_item(plti_pkg::MODE_REV, 4'd0, 32'd0, 32'd0, 32'h0005_0000);
        send_item(plti_pkg::MODE_REV, 4'd0, 32'd0, 32'd0, 32'h0000_0000);
        send_item(plti_pkg::MODE_REV, 4'd0, 32'd0, 32'd0, 32'h0002_8000);

        // long receiver hold-off so the block backs up
        hold_off = 400;
        repeat (6) random_query();
        drain();

        for (int phase = 0; phase < 14; phase++) begin
            drain();
            case (phase)
                0: write_count(5'd0);
                1: write_count(5'd16);
                2: write_count(5'd31);
                3: write_count(5'd1);
                default: write_count(5'($urandom_range(2, 16)));
            endcase
            if (phase >= 11) idle_on = 1'b0;
            load_table(phase % 4 != 3);
            for (int k = 0; k < 42; k++) random_query();
        end
        drain();
        write_count(5'd2);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result('{value: m_axis_tdata, sat: m_axis_tuser});
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end
endmodule

### files.f
rtl/plti_pkg.sv
rtl/plti_cell.sv
rtl/plti_div.sv
rtl/piecewise_linear_table_interp.sv
dv/tb.sv
